@@ rtl/core/nmp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nmp_pkg
// shared types and codes of the node maintenance planner
// ----------------------------------------------------------------------------
package nmp_pkg;

	localparam int NODES_DEF  = 16;
	localparam int SLOT_MAX_W = 8;   // enough for the largest table

	localparam logic [1:0] ACT_UPDATE = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_PLAN   = 2'd2;

	localparam logic [1:0] KIND_BRANCH     = 2'd0;
	localparam logic [1:0] KIND_COMPACT    = 2'd1;
	localparam logic [1:0] KIND_CHECKPOINT = 2'd2;
	localparam logic [1:0] KIND_BACKUP     = 2'd3;

	localparam logic [1:0] STAT_NONE   = 2'd0;
	localparam logic [1:0] STAT_CHOSEN = 2'd1;
	localparam logic [1:0] STAT_RETRY  = 2'd2;

	localparam logic [2:0] RSN_NONE   = 3'd0;
	localparam logic [2:0] RSN_RETRY  = 3'd1;
	localparam logic [2:0] RSN_SIZE   = 3'd2;
	localparam logic [2:0] RSN_AGE    = 3'd3;
	localparam logic [2:0] RSN_BRANCH = 3'd4;

	localparam logic CFG_TTL_AGE  = 1'b0;
	localparam logic CFG_TTL_USED = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  plan_kind;
		logic [1:0]  member_mask;
		logic [3:0]  slot;
		logic [31:0] node_id;
		logic [31:0] used_size;
		logic [15:0] branch_total;
		logic [31:0] backup_number;
		logic [63:0] lsn_minimum;
		logic [63:0] time_value;
		logic        lock_flag;
		logic [63:0] limit_a;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  reason_code;
		logic [3:0]  chosen_slot;
		logic [31:0] chosen_id;
	} res_t;

	typedef struct packed {
		logic                  upd;
		logic                  rem;
		logic                  lck;
		logic [SLOT_MAX_W-1:0] lck_slot;
	} ctl_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] lim;
		logic [63:0] now;
		logic [63:0] ttl_age;
		logic [31:0] ttl_used;
	} plan_t;

	// running best handed from cell to cell
	typedef struct packed {
		logic                  valid;
		logic                  a_valid;
		logic [31:0]           a_key;
		logic [31:0]           a_id;
		logic [SLOT_MAX_W-1:0] a_slot;
		logic                  b_valid;
		logic [31:0]           b_key;
		logic [31:0]           b_id;
		logic [SLOT_MAX_W-1:0] b_slot;
		logic                  retry;
	} word_t;

endpackage
`default_nettype wire

@@ rtl/core/nmp_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nmp_cell
// one table slot: holds its entry and folds it into the passing best word
// ----------------------------------------------------------------------------
module nmp_cell #(
	parameter int IDX = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire nmp_pkg::ctl_t  ctl,
	input  wire nmp_pkg::cmd_t  cmd,
	input  wire nmp_pkg::plan_t plan,
	input  wire nmp_pkg::word_t w_in,
	output nmp_pkg::word_t      w_out
);
	import nmp_pkg::*;

	localparam logic [SLOT_MAX_W-1:0] MY_SLOT = SLOT_MAX_W'(IDX);

	logic        br_q, cp_q, lk_q;
	logic [31:0] id_q, used_q, backup_q;
	logic [15:0] branches_q;
	logic [63:0] lsn_q, time_q;
	logic        hit;
	word_t       w_nxt, w_s1;

	logic        a_cand, b_cand, qual, age_ok;
	logic [31:0] a_key;
	logic [63:0] age;

	assign hit = (IDX < 16) && (cmd.slot == 4'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			br_q <= 1'b0;
			cp_q <= 1'b0;
			lk_q <= 1'b0;
		end else begin
			if (ctl.upd && hit) begin
				br_q <= br_q | cmd.member_mask[0];
				cp_q <= cp_q | cmd.member_mask[1];
				lk_q <= cmd.lock_flag;
			end else if (ctl.rem && hit) begin
				br_q <= br_q & ~cmd.member_mask[0];
				cp_q <= cp_q & ~cmd.member_mask[1];
			end
			if (ctl.lck && ctl.lck_slot == MY_SLOT)
				lk_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd && hit) begin
			id_q       <= cmd.node_id;
			used_q     <= cmd.used_size;
			branches_q <= cmd.branch_total;
			backup_q   <= cmd.backup_number;
			lsn_q      <= cmd.lsn_minimum;
			time_q     <= cmd.time_value;
		end
	end

	always_comb begin
		age    = plan.now - time_q;
		age_ok = (used_q >= plan.ttl_used) && (age >= plan.ttl_age);
		case (plan.kind)
			KIND_BRANCH:     qual = age_ok;
			KIND_CHECKPOINT: qual = (lsn_q <= plan.lim);
			KIND_BACKUP:     qual = ({32'd0, backup_q} < plan.lim);
			default:         qual = 1'b0;
		endcase
		a_key  = (plan.kind == KIND_COMPACT) ? {16'd0, branches_q} : used_q;
		a_cand = !lk_q && ((plan.kind == KIND_COMPACT) ? cp_q : br_q);
		b_cand = !lk_q && br_q && qual;

		w_nxt = w_in;
		// strictly above only: equal key and id keep the lower slot
		if (a_cand && (!w_in.a_valid || a_key > w_in.a_key ||
				(a_key == w_in.a_key && id_q > w_in.a_id))) begin
			w_nxt.a_valid = 1'b1;
			w_nxt.a_key   = a_key;
			w_nxt.a_id    = id_q;
			w_nxt.a_slot  = MY_SLOT;
		end
		if (b_cand && (!w_in.b_valid || used_q > w_in.b_key ||
				(used_q == w_in.b_key && id_q > w_in.b_id))) begin
			w_nxt.b_valid = 1'b1;
			w_nxt.b_key   = used_q;
			w_nxt.b_id    = id_q;
			w_nxt.b_slot  = MY_SLOT;
		end
		if (br_q && lk_q && qual)
			w_nxt.retry = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			w_s1 <= '0;
		else
			w_s1 <= w_nxt;
	end

	assign w_out = w_s1;

endmodule
`default_nettype wire

@@ rtl/core/node_maintenance_planner_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// node_maintenance_planner_unit
// table of index nodes with maintenance plan selection over a row of cells
// ----------------------------------------------------------------------------
// update and remove words: result next cycle, one word per cycle unless busy
// plan words: launch_q, a register in each cell, then done_q; the best word
//   walks the row one slot per cycle; busy holds further words off meanwhile
// the receiver cannot stall: done is high for exactly one cycle per word
// reset clears membership and lock flags and both ttl registers at once
// ----------------------------------------------------------------------------
module node_maintenance_planner_unit #(
	parameter int NODES = nmp_pkg::NODES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire nmp_pkg::cmd_t cmd,
	output logic              done,
	output nmp_pkg::res_t     result,
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [63:0]  cfg_data
);
	import nmp_pkg::*;

	// control
	state_t      state_q, state_nxt;
	logic        accept;
	logic        launch_q;
	logic        done_q;
	res_t        result_q, res_nxt;
	ctl_t        ctl;
	plan_t       plan;

	// latched plan request and configuration
	logic [1:0]  kind_q;
	logic [63:0] lim_q, now_q;
	logic [63:0] ttl_age_q;
	logic [31:0] ttl_used_q;

	// best word at each point along the row
	word_t       chain [NODES+1];
	word_t       fin;
	logic        chose;
	logic [SLOT_MAX_W-1:0] pick_slot;
	logic [31:0] pick_id;

	assign accept = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_age_q  <= '0;
			ttl_used_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TTL_AGE:  ttl_age_q  <= cfg_data;
				CFG_TTL_USED: ttl_used_q <= cfg_data[31:0];
				default:      ;
			endcase
		end
	end

	// plan request fields stay put for the whole walk
	always_ff @(posedge clk) begin
		if (accept && cmd.action == ACT_PLAN) begin
			kind_q <= cmd.plan_kind;
			lim_q  <= cmd.limit_a;
			now_q  <= cmd.time_value;
		end
	end

	assign plan = '{kind: kind_q, lim: lim_q, now: now_q,
		ttl_age: ttl_age_q, ttl_used: ttl_used_q};

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && cmd.action == ACT_PLAN) state_nxt = ST_SCAN;
			ST_SCAN: if (fin.valid) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// outputs of the state machine
	always_comb begin
		busy = (state_q == ST_SCAN);
	end

	// table writes land at the accept edge; the lock lands as the walk ends
	always_comb begin
		ctl.upd      = accept && cmd.action == ACT_UPDATE;
		ctl.rem      = accept && cmd.action == ACT_REMOVE;
		ctl.lck      = fin.valid && chose;
		ctl.lck_slot = pick_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			launch_q <= 1'b0;
		else
			launch_q <= accept && cmd.action == ACT_PLAN;
	end

	// empty best word enters the first cell
	assign chain[0] = '{valid: launch_q, default: '0};

	for (genvar g = 0; g < NODES; g++) begin : g_cell
		nmp_cell #(.IDX(g)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.cmd   (cmd),
			.plan  (plan),
			.w_in  (chain[g]),
			.w_out (chain[g+1])
		);
	end

	assign fin = chain[NODES];

	// decide from the best word at the end of the row
	always_comb begin
		res_nxt   = '0;
		chose     = 1'b0;
		pick_slot = fin.b_slot;
		pick_id   = fin.b_id;
		case (kind_q)
			KIND_BRANCH: begin
				// highest unlocked member big enough, else oldest-enough by order
				if (fin.a_valid && {32'd0, fin.a_key} >= lim_q) begin
					chose                = 1'b1;
					pick_slot            = fin.a_slot;
					pick_id              = fin.a_id;
					res_nxt.reason_code  = RSN_SIZE;
				end else if (fin.b_valid) begin
					chose                = 1'b1;
					res_nxt.reason_code  = RSN_AGE;
				end
			end
			KIND_COMPACT: begin
				if (fin.a_valid && {32'd0, fin.a_key} >= lim_q) begin
					chose                = 1'b1;
					pick_slot            = fin.a_slot;
					pick_id              = fin.a_id;
					res_nxt.reason_code  = RSN_BRANCH;
				end
			end
			default: begin
				// checkpoint and backup: a locked qualifier only means retry
				if (fin.b_valid) begin
					chose = 1'b1;
				end else if (fin.retry) begin
					res_nxt.status      = STAT_RETRY;
					res_nxt.reason_code = RSN_RETRY;
				end
			end
		endcase
		if (chose) begin
			res_nxt.status      = STAT_CHOSEN;
			res_nxt.chosen_slot = 4'(pick_slot);
			res_nxt.chosen_id   = pick_id;
		end
	end

	// result register; non-plan words answer all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= fin.valid || (accept && cmd.action != ACT_PLAN);
	end

	always_ff @(posedge clk) begin
		if (fin.valid)
			result_q <= res_nxt;
		else
			result_q <= '0;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// drives update, remove, plan and unused-action words into the node maintenance
// planner and checks every result word against a predictor of the node table
// ----------------------------------------------------------------------------
module tb_top;
	import nmp_pkg::*;

	localparam int SLOTS     = 16;
	localparam int LIMIT_CYC = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	cmd_t        cmd = '0;
	logic        done;
	res_t        result;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [63:0] cfg_data = '0;

	node_maintenance_planner_unit #(.NODES(SLOTS)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// predictor copy of the node table and ttl registers
	logic [63:0] age_min;
	logic [31:0] used_min;
	logic        mem_br[SLOTS];
	logic        mem_cp[SLOTS];
	logic        lck[SLOTS];
	logic [31:0] n_id[SLOTS];
	logic [31:0] n_used[SLOTS];
	logic [15:0] n_br[SLOTS];
	logic [31:0] n_bk[SLOTS];
	logic [63:0] n_lsn[SLOTS];
	logic [63:0] n_tm[SLOTS];
	logic        written[SLOTS];

	res_t pending_res[$];
	int   mismatches = 0;
	int   words_out = 0;
	int   plans_sent = 0;
	int   cycles = 0;

	// true when slot a ranks above slot b
	function automatic bit ranks_above(int a, int b, bit by_branches);
		logic [31:0] ka, kb;
		ka = by_branches ? {16'd0, n_br[a]} : n_used[a];
		kb = by_branches ? {16'd0, n_br[b]} : n_used[b];
		if (ka != kb) return ka > kb;
		if (n_id[a] != n_id[b]) return n_id[a] > n_id[b];
		return a < b;
	endfunction

	function automatic void rank_members(bit by_branches, output int ord[SLOTS],
			output int cnt);
		int k;
		cnt = 0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!(by_branches ? mem_cp[i] : mem_br[i])) continue;
			k = cnt;
			while (k > 0 && ranks_above(i, ord[k-1], by_branches)) begin
				ord[k] = ord[k-1];
				k--;
			end
			ord[k] = i;
			cnt++;
		end
	endfunction

	function automatic res_t plan_outcome(cmd_t c);
		res_t r;
		int   ord[SLOTS];
		int   cnt, k, pick, s;
		bit   retry, q;
		r = '0;
		pick = -1;
		retry = 0;
		case (c.action)
			ACT_UPDATE: begin
				n_id[c.slot] = c.node_id;
				n_used[c.slot] = c.used_size;
				n_br[c.slot] = c.branch_total;
				n_bk[c.slot] = c.backup_number;
				n_lsn[c.slot] = c.lsn_minimum;
				n_tm[c.slot] = c.time_value;
				lck[c.slot] = c.lock_flag;
				written[c.slot] = 1'b1;
				if (c.member_mask[0]) mem_br[c.slot] = 1'b1;
				if (c.member_mask[1]) mem_cp[c.slot] = 1'b1;
			end
			ACT_REMOVE: begin
				if (c.member_mask[0]) mem_br[c.slot] = 1'b0;
				if (c.member_mask[1]) mem_cp[c.slot] = 1'b0;
			end
			ACT_PLAN: begin
				rank_members(c.plan_kind == KIND_COMPACT, ord, cnt);
				if (c.plan_kind == KIND_BRANCH || c.plan_kind == KIND_COMPACT) begin
					for (k = 0; k < cnt; k++) if (!lck[ord[k]]) break;
					if (k < cnt) begin
						if (c.plan_kind == KIND_COMPACT) begin
							if ({48'd0, n_br[ord[k]]} >= c.limit_a) begin
								pick = ord[k];
								r.reason_code = RSN_BRANCH;
							end
						end else if ({32'd0, n_used[ord[k]]} >= c.limit_a) begin
							pick = ord[k];
							r.reason_code = RSN_SIZE;
						end else begin
							// age fallback walks on down the order
							for (; k < cnt; k++) begin
								s = ord[k];
								if (lck[s]) continue;
								if (n_used[s] >= used_min && c.time_value - n_tm[s] >= age_min) begin
									pick = s;
									r.reason_code = RSN_AGE;
									break;
								end
							end
						end
					end
				end else begin
					for (k = 0; k < cnt; k++) begin
						s = ord[k];
						q = (c.plan_kind == KIND_CHECKPOINT) ? (n_lsn[s] <= c.limit_a)
							: ({32'd0, n_bk[s]} < c.limit_a);
						if (!q) continue;
						if (lck[s]) begin
							retry = 1;
							continue;
						end
						pick = s;
						r.reason_code = RSN_NONE;
						break;
					end
					if (pick < 0 && retry) begin
						r.status = STAT_RETRY;
						r.reason_code = RSN_RETRY;
					end
				end
				if (pick >= 0) begin
					lck[pick] = 1'b1;
					r.status = STAT_CHOSEN;
					r.chosen_slot = pick[3:0];
					r.chosen_id = n_id[pick];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// result side: compare each word against the oldest expectation
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (done) begin
			words_out <= words_out + 1;
			if (pending_res.size() == 0) begin
				if (mismatches < 10) $display("unexpected result word %h", result);
				mismatches++;
			end else begin
				if (result.status !== pending_res[0].status ||
						result.reason_code !== pending_res[0].reason_code ||
						result.chosen_slot !== pending_res[0].chosen_slot ||
						result.chosen_id !== pending_res[0].chosen_id) begin
					if (mismatches < 10)
						$display("mismatch: expected %h got %h", pending_res[0], result);
					mismatches++;
				end
				void'(pending_res.pop_front());
			end
		end
		if (cycles > LIMIT_CYC) begin
			$display("tb: failure");
			$finish;
		end
	end

	// hand one word over, wait for it to be taken, then drop start
	task automatic send_word(cmd_t c, bit check_typed, res_t typed);
		res_t r;
		cmd <= c;
		start <= 1'b1;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		r = plan_outcome(c);
		if (check_typed && r != typed) begin
			mismatches++;
			$display("typed expectation differs from predictor for %h", c);
		end
		pending_res.push_back(r);
		if (c.action == ACT_PLAN) plans_sent++;
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		while (pending_res.size() != 0) @(posedge clk);
		repeat (SLOTS + 6) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TTL_AGE) age_min = v;
		else used_min = v[31:0];
		@(posedge clk);
	endtask

	function automatic cmd_t mk(logic [1:0] act, logic [1:0] kind, logic [1:0] mask,
			int slot, logic [31:0] id, logic [31:0] used, logic [15:0] br,
			logic [31:0] bk, logic [63:0] lsn, logic [63:0] tv, logic lk,
			logic [63:0] lim);
		cmd_t c;
		c = '{act, kind, mask, slot[3:0], id, used, br, bk, lsn, tv, lk, lim};
		return c;
	endfunction

	function automatic cmd_t random_word(int pool);
		cmd_t         c;
		int           sl;
		logic [319:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom};
		c = raw[$bits(cmd_t)-1:0];
		sl = $urandom_range(0, pool - 1);
		c.slot = sl[3:0];
		case ($urandom_range(0, 9))
			0, 1, 2, 3: c.action = ACT_UPDATE;
			4: c.action = ACT_REMOVE;
			5: c.action = 2'd3;
			default: c.action = ACT_PLAN;
		endcase
		// narrow values so ties, thresholds and ages meet often
		if ($urandom_range(0, 1)) begin
			c.used_size = $urandom_range(0, 7);
			c.branch_total = $urandom_range(0, 7);
			c.node_id = $urandom_range(0, 3);
			c.backup_number = $urandom_range(0, 7);
			c.lsn_minimum = $urandom_range(0, 7);
			c.time_value = $urandom_range(0, 40);
			c.limit_a = $urandom_range(0, 8);
		end
		if ($urandom_range(0, 2) != 0) c.lock_flag = 1'b0;
		// members are always written; a remove of an unwritten slot becomes a plan word
		if (c.action == ACT_REMOVE && !written[c.slot]) c.action = ACT_PLAN;
		return c;
	endfunction

	typedef struct {
		cmd_t c;
		bit   typed;
		res_t r;
	} step_t;

	initial begin
		step_t dir[$];
		res_t  z;
		cmd_t  c;
		int    pool;
		z = '0;
		age_min = '0;
		used_min = '0;
		for (int i = 0; i < SLOTS; i++) begin
			mem_br[i] = 0; mem_cp[i] = 0; lck[i] = 0; written[i] = 0;
			n_id[i] = 0; n_used[i] = 0; n_br[i] = 0; n_bk[i] = 0; n_lsn[i] = 0; n_tm[i] = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: empty plans, extremes, ties, locking, retry
		dir.push_back('{mk(ACT_PLAN, KIND_BRANCH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, z});
		dir.push_back('{mk(ACT_PLAN, KIND_BACKUP, 0, 0, 0, 0, 0, 0, 0, 0, 0, '1), 1, z});
		dir.push_back('{mk(ACT_UPDATE, 0, 2'd3, 15, '1, '1, '1, '1, '1, '1, 0, 0), 1, z});
		dir.push_back('{mk(ACT_UPDATE, 0, 2'd3, 0, 0, 0, 0, 0, 0, 0, 1, 0), 1, z});
		dir.push_back('{mk(ACT_UPDATE, 0, 2'd1, 3, 7, 5, 2, 4, 9, 100, 0, 0), 0, z});
		dir.push_back('{mk(ACT_UPDATE, 0, 2'd1, 4, 7, 5, 2, 4, 9, 100, 0, 0), 0, z});
		dir.push_back('{mk(2'd3, 3, 3, 3, '1, '1, '1, '1, '1, '1, 1, '1), 1, z});
		dir.push_back('{mk(ACT_PLAN, KIND_BRANCH, 0, 0, 0, 0, 0, 0, 0, 0, 0, '1), 0, z});
		dir.push_back('{mk(ACT_PLAN, KIND_COMPACT, 0, 0, 0, 0, 0, 0, 0, 0, 0, '1), 1, z});
		// both compact members are locked by now
		dir.push_back('{mk(ACT_PLAN, KIND_COMPACT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, z});
		dir.push_back('{mk(ACT_PLAN, KIND_BRANCH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5), 0, z});
		dir.push_back('{mk(ACT_PLAN, KIND_CHECKPOINT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, '{STAT_RETRY, RSN_RETRY, 4'd0, 32'd0}});
		dir.push_back('{mk(ACT_PLAN, KIND_CHECKPOINT, 0, 0, 0, 0, 0, 0, 0, 0, 0, '1), 0, z});
		dir.push_back('{mk(ACT_PLAN, KIND_BACKUP, 0, 0, 0, 0, 0, 0, 0, 0, 0, '1), 0, z});
		dir.push_back('{mk(ACT_REMOVE, 0, 2'd3, 15, 0, 0, 0, 0, 0, 0, 0, 0), 1, z});
		dir.push_back('{mk(ACT_UPDATE, 0, 2'd2, 3, 1, 0, 0, 0, 0, 50, 0, 0), 1, z});
		dir.push_back('{mk(ACT_PLAN, KIND_BRANCH, 0, 0, 0, 0, 0, 0, 0, '1, 0, '1), 0, z});
		foreach (dir[i]) begin
			send_word(dir[i].c, dir[i].typed, dir[i].r);
			idle_gap();
		end
		drain();

		// random phases, each with the ttl registers written anew
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin write_reg(CFG_TTL_AGE, '1); write_reg(CFG_TTL_USED, '1); end
				1: begin write_reg(CFG_TTL_AGE, 0); write_reg(CFG_TTL_USED, 0); end
				default: begin
					write_reg(CFG_TTL_AGE, $urandom_range(0, 30));
					write_reg(CFG_TTL_USED, $urandom_range(0, 6));
				end
			endcase
			pool = (ph % 2) ? SLOTS : 4;
			repeat (250) begin
				c = random_word(pool);
				send_word(c, 0, z);
				if ($urandom_range(0, 3) == 0) idle_gap();
			end
			// hold off until the table has answered everything
			drain();
		end

		$display("run covered %0d plan words among %0d result words over eight ttl settings",
			plans_sent, words_out);
		if (mismatches == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/nmp_pkg.sv
rtl/core/nmp_cell.sv
rtl/core/node_maintenance_planner_unit.sv
bench/tb_top.sv
